### rtl/core/wblr_pkg.sv
// Shared constants, codes and types for the wrapping byte list generator.
package wblr_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int VAL_W      = 8;
   localparam int CFG_W      = 5;
   localparam int POS_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
   localparam int TGT_W      = $clog2(LIST_DEPTH + 255);

   localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(16);

   localparam logic [VAL_W-1:0] SCR_MUL = 8'd5;
   localparam logic [VAL_W-1:0] SCR_ADD = 8'd1;

   localparam logic [2:0] MODE_DRAW    = 3'd0;
   localparam logic [2:0] MODE_PEEK    = 3'd1;
   localparam logic [2:0] MODE_SKIP    = 3'd2;
   localparam logic [2:0] MODE_LOAD    = 3'd3;
   localparam logic [2:0] MODE_RESTART = 3'd4;
   localparam logic [2:0] MODE_SETIDX  = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_PEEK = 5'b00100,
      ST_DRAW = 5'b01000,
      ST_PASS = 5'b10000
   } state_type;

endpackage

### rtl/core/wrapping_byte_list_rng_top.sv
// Top level of the wrapping byte list generator: control sequencer around two list RAMs.
// Load, set index and unused modes: result the cycle after the transfer, busy stays low.
// Draw: result registered from the DRAW state; a wrapping draw then rescrambles the list.
// Peek and skip: the DIV state subtracts the length from position plus offset until below
// the length, then PEEK reads (peek) or a write-back walk follows (skip, when it wraps).
// Restart: result next cycle, then a copy walk over the whole depth; results cannot stall.
// Synchronous reset: position zero, length 16; list contents undefined until loaded.
module wrapping_byte_list_rng_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_mode,
   input  logic [7:0]                   req_offset,
   input  logic [3:0]                   req_entry_index,
   input  logic [7:0]                   req_entry_value,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_value,
   output logic                         rsp_status,
   input  logic                         csr_write_enable,
   input  logic [wblr_pkg::CFG_W-1:0]   csr_write_data
);
   import wblr_pkg::*;

   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [CFG_W-1:0]       list_length_ff;
   logic                   is_peek_ff, is_peek_in;
   logic [TGT_W-1:0]       target_ff, target_in;
   logic [VAL_W-1:0]       mul_a_ff, mul_a_in;
   logic [VAL_W-1:0]       mul_c_ff, mul_c_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   src_base_ff, src_base_in;
   logic [LEN_W-1:0]       idx_ff, idx_in;
   logic [LEN_W-1:0]       count_ff, count_in;
   logic                   pend_ff, pend_in;
   logic [POS_W-1:0]       waddr_ff, waddr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       pos_next;
   logic [POS_W-1:0]       rd_addr;
   logic                   cur_we, base_we;
   logic [POS_W-1:0]       cur_waddr;
   logic [VAL_W-1:0]       cur_wdata, load_value;
   logic [VAL_W-1:0]       cur_rd, base_rd, xform;

   wblr_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_addr (rd_addr),
      .rd_data (cur_rd)
   );

   wblr_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (POS_W'(req_entry_index)),
      .wr_data (load_value),
      .rd_addr (rd_addr),
      .rd_data (base_rd)
   );

   always_comb begin
      if (list_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (TGT_W'(list_length_ff) > TGT_W'(LIST_DEPTH)) begin
         len_eff = LEN_W'(LIST_DEPTH);
      end else begin
         len_eff = LEN_W'(list_length_ff);
      end
   end

   assign pos_next   = LEN_W'(pos_ff) + LEN_W'(1);
   assign load_value = (req_entry_index == 4'd0 && req_entry_value == 8'd0) ? 8'd1
                                                                            : req_entry_value;
   assign xform      = 8'(mul_a_ff * (src_base_ff ? base_rd : cur_rd) + mul_c_ff);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      is_peek_in    = is_peek_ff;
      target_in     = target_ff;
      mul_a_in      = mul_a_ff;
      mul_c_in      = mul_c_ff;
      wrapped_in    = wrapped_ff;
      src_base_in   = src_base_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_in       = 1'b0;
      waddr_in      = waddr_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = 1'b0;
      rd_addr       = pos_ff;
      cur_we        = 1'b0;
      base_we       = 1'b0;
      cur_waddr     = POS_W'(req_entry_index);
      cur_wdata     = load_value;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_DRAW: begin
                     rd_addr     = pos_ff;
                     mul_a_in    = SCR_MUL;
                     mul_c_in    = SCR_ADD;
                     src_base_in = 1'b0;
                     if (pos_next >= len_eff) begin
                        pos_in     = '0;
                        wrapped_in = 1'b1;
                     end else begin
                        pos_in     = POS_W'(pos_next);
                        wrapped_in = 1'b0;
                     end
                     state_in = ST_DRAW;
                  end
                  MODE_PEEK, MODE_SKIP: begin
                     target_in   = TGT_W'(pos_ff) + TGT_W'(req_offset);
                     mul_a_in    = 8'd1;
                     mul_c_in    = 8'd0;
                     wrapped_in  = 1'b0;
                     src_base_in = 1'b0;
                     is_peek_in  = (req_mode == MODE_PEEK);
                     state_in    = ST_DIV;
                  end
                  MODE_LOAD: begin
                     if (TGT_W'(req_entry_index) < TGT_W'(LIST_DEPTH)) begin
                        cur_we  = 1'b1;
                        base_we = 1'b1;
                     end
                     pos_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_RESTART: begin
                     pos_in       = '0;
                     src_base_in  = 1'b1;
                     mul_a_in     = 8'd1;
                     mul_c_in     = 8'd0;
                     idx_in       = '0;
                     count_in     = LEN_W'(LIST_DEPTH);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_PASS;
                  end
                  MODE_SETIDX: begin
                     if (TGT_W'(req_entry_index) < TGT_W'(len_eff)) begin
                        pos_in = POS_W'(req_entry_index);
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rd_addr = POS_W'(target_ff);
            if (target_ff >= TGT_W'(len_eff)) begin
               target_in  = target_ff - TGT_W'(len_eff);
               mul_a_in   = 8'(mul_a_ff * SCR_MUL);
               mul_c_in   = 8'(mul_c_ff * SCR_MUL + SCR_ADD);
               wrapped_in = 1'b1;
            end else if (is_peek_ff) begin
               state_in = ST_PEEK;
            end else begin
               pos_in       = POS_W'(target_ff);
               rsp_valid_in = 1'b1;
               if (wrapped_ff) begin
                  idx_in   = '0;
                  count_in = len_eff;
                  state_in = ST_PASS;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PEEK: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = xform;
            state_in     = ST_IDLE;
         end
         ST_DRAW: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = cur_rd;
            if (wrapped_ff) begin
               idx_in   = '0;
               count_in = len_eff;
               state_in = ST_PASS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PASS: begin
            rd_addr = POS_W'(idx_ff);
            if (idx_ff < count_ff) begin
               idx_in   = idx_ff + LEN_W'(1);
               pend_in  = 1'b1;
               waddr_in = POS_W'(idx_ff);
            end
            if (pend_ff) begin
               cur_we    = 1'b1;
               cur_waddr = waddr_ff;
               cur_wdata = xform;
            end
            if (idx_ff == count_ff && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         list_length_ff <= LEN_RESET;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            list_length_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      is_peek_ff    <= is_peek_in;
      target_ff     <= target_in;
      mul_a_ff      <= mul_a_in;
      mul_c_ff      <= mul_c_in;
      wrapped_ff    <= wrapped_in;
      src_base_ff   <= src_base_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      waddr_ff      <= waddr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### rtl/core/wblr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wblr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/wrapping_byte_list_rng_top_tb.sv
// Self-checking testbench for the wrapping byte list generator: directed table, then random phases.
`timescale 1ns / 1ps

module wrapping_byte_list_rng_top_tb;
   import wblr_pkg::*;

   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;
   localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int PHASES        = 8;
   localparam int NO_LEN        = -1;

   typedef struct {
      logic [2:0] mode;
      logic [7:0] offset;
      logic [3:0] entry_index;
      logic [7:0] entry_value;
   } byte_req_type;

   typedef struct {
      logic [7:0] value;
      logic       status;
   } byte_rsp_type;

   typedef struct {
      int           new_len;
      byte_req_type req;
      bit           typed;
      byte_rsp_type rsp;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [2:0]       req_mode;
   logic [7:0]       req_offset;
   logic [3:0]       req_entry_index;
   logic [7:0]       req_entry_value;
   logic             rsp_valid;
   logic [7:0]       rsp_value;
   logic             rsp_status;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;

   logic [7:0]       list_now  [LIST_DEPTH];
   logic [7:0]       list_base [LIST_DEPTH];
   int unsigned      read_pos;
   logic [CFG_W-1:0] length_reg;

   byte_rsp_type pending_replies [$];
   plan_row_type directed_plan [$];

   int mismatches;
   int replies_seen;
   int requests_sent;
   int length_writes;
   int rescrambles;

   wrapping_byte_list_rng_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_offset       (req_offset),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [7:0] scramble_byte(logic [7:0] b);
      return 8'(b * SCR_MUL + SCR_ADD);
   endfunction

   function automatic int unsigned active_length();
      if (length_reg == '0) return 1;
      if (int'(length_reg) > LIST_DEPTH) return LIST_DEPTH;
      return int'(length_reg);
   endfunction

   function automatic void rescramble_list(int unsigned len);
      for (int i = 0; i < len; i++) list_now[i] = scramble_byte(list_now[i]);
      rescrambles++;
   endfunction

   function automatic byte_rsp_type advance_byte_list(byte_req_type rq);
      byte_rsp_type rs;
      int unsigned  len;
      int unsigned  target;
      logic [7:0]   b;
      len       = active_length();
      rs.value  = '0;
      rs.status = 1'b0;
      target    = read_pos + rq.offset;
      case (rq.mode)
         MODE_DRAW: begin
            rs.value = list_now[read_pos % LIST_DEPTH];
            read_pos++;
            if (read_pos >= len) begin
               read_pos = 0;
               rescramble_list(len);
            end
         end
         MODE_PEEK: begin
            b = list_now[target % len];
            for (int w = 0; w < target / len; w++) b = scramble_byte(b);
            rs.value = b;
         end
         MODE_SKIP: begin
            for (int w = 0; w < target / len; w++) rescramble_list(len);
            read_pos = target % len;
         end
         MODE_LOAD: begin
            b = rq.entry_value;
            if (rq.entry_index == '0 && b == '0) b = 8'd1;
            list_now[rq.entry_index]  = b;
            list_base[rq.entry_index] = b;
            read_pos = 0;
         end
         MODE_RESTART: begin
            list_now = list_base;
            read_pos = 0;
         end
         MODE_SETIDX: begin
            if (rq.entry_index < len) read_pos = rq.entry_index;
            else rs.status = 1'b1;
         end
         default: ;
      endcase
      return rs;
   endfunction

   function automatic plan_row_type make_row(int new_len, logic [2:0] mode, logic [7:0] offset,
                                             logic [3:0] idx, logic [7:0] data, bit typed,
                                             logic [7:0] exp_value, logic exp_status);
      plan_row_type row;
      row.new_len         = new_len;
      row.req.mode        = mode;
      row.req.offset      = offset;
      row.req.entry_index = idx;
      row.req.entry_value = data;
      row.typed           = typed;
      row.rsp.value       = exp_value;
      row.rsp.status      = exp_status;
      return row;
   endfunction

   function automatic void plan_add(plan_row_type row);
      directed_plan.insert(directed_plan.size(), row);
   endfunction

   function automatic byte_req_type random_request();
      byte_req_type rq;
      int unsigned  pick;
      pick           = $urandom_range(0, 99);
      rq.offset      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
      rq.entry_index = 4'($urandom);
      rq.entry_value = 8'($urandom);
      if (pick < 32) rq.mode = MODE_DRAW;
      else if (pick < 48) rq.mode = MODE_PEEK;
      else if (pick < 61) rq.mode = MODE_SKIP;
      else if (pick < 69) rq.mode = MODE_LOAD;
      else if (pick < 73) rq.mode = MODE_RESTART;
      else if (pick < 95) rq.mode = MODE_SETIDX;
      else if (pick < 97) rq.mode = MODE_SPARE_A;
      else rq.mode = MODE_SPARE_B;
      if (rq.mode == MODE_LOAD && $urandom_range(0, 7) == 0) begin
         rq.entry_index = '0;
         rq.entry_value = '0;
      end
      return rq;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hold start until the transfer, then predict
   task automatic send_request(byte_req_type rq, bit typed, byte_rsp_type typed_rsp);
      byte_rsp_type predicted;
      start           <= 1'b1;
      req_mode        <= rq.mode;
      req_offset      <= rq.offset;
      req_entry_index <= rq.entry_index;
      req_entry_value <= rq.entry_value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = advance_byte_list(rq);
      if (typed) predicted = typed_rsp;
      pending_replies.insert(pending_replies.size(), predicted);
      requests_sent++;
   endtask

   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // drop start and drain all replies and background walks
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [CFG_W-1:0] len_value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_reg = len_value;
      length_writes++;
   endtask

   always @(posedge clock) begin
      byte_rsp_type want;
      if (!reset && rsp_valid) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected reply value %h status %b", $time, rsp_value, rsp_status);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_value !== want.value || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: reply mismatch: expected value %h status %b, got value %h status %b",
                           $time, want.value, want.status, rsp_value, rsp_status);
            end
         end
      end
   end

   initial begin
      byte_rsp_type no_rsp;
      int           phase_len [PHASES];
      bit           steady;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_mode         <= '0;
      req_offset       <= '0;
      req_entry_index  <= '0;
      req_entry_value  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      read_pos      = 0;
      length_reg    = LEN_RESET;
      mismatches    = 0;
      replies_seen  = 0;
      requests_sent = 0;
      length_writes = 0;
      rescrambles   = 0;
      steady        = 1'b0;
      no_rsp.value  = '0;
      no_rsp.status = 1'b0;
      phase_len     = '{16, 1, 0, 31, 17, 7, 0, 0};
      phase_len[6]  = $urandom_range(1, 16);
      phase_len[7]  = $urandom_range(0, 31);

      plan_add(make_row(NO_LEN, MODE_SETIDX, 8'd0, 4'd15, 8'd0, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SETIDX, 8'd0, 4'd0, 8'd0, 1'b1, 8'd0, 1'b0));
      for (int i = 0; i < LIST_DEPTH; i++)
         plan_add(make_row(NO_LEN, MODE_LOAD, 8'd0, 4'(i),
                           (i == 0 || i == 1) ? 8'h00 :
                           (i == 15) ? 8'hFF : 8'(i * 37 + 3),
                           1'b1, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_DRAW, 8'd0, 4'd0, 8'd0, 1'b1, 8'd1, 1'b0));
      plan_add(make_row(NO_LEN, MODE_PEEK, 8'd255, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SKIP, 8'd255, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SETIDX, 8'd0, 4'd15, 8'd0, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_DRAW, 8'd0, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_RESTART, 8'd0, 4'd0, 8'd0, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_DRAW, 8'd0, 4'd0, 8'd0, 1'b1, 8'd1, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SPARE_A, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SPARE_B, 8'hFF, 4'hF, 8'hFF, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(4, MODE_SETIDX, 8'd0, 4'd4, 8'd0, 1'b1, 8'd0, 1'b1));
      plan_add(make_row(31, MODE_SETIDX, 8'd0, 4'd15, 8'd0, 1'b1, 8'd0, 1'b0));
      plan_add(make_row(3, MODE_DRAW, 8'd0, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      plan_add(make_row(0, MODE_PEEK, 8'd255, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));
      plan_add(make_row(NO_LEN, MODE_SKIP, 8'd255, 4'd0, 8'd0, 1'b0, 8'd0, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].new_len != NO_LEN) begin
            wait_idle();
            write_length(CFG_W'(directed_plan[i].new_len));
         end
         send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].rsp);
         idle_gap(pick_gap());
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         write_length(CFG_W'(phase_len[ph]));
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if ($urandom_range(0, 63) == 0) steady = !steady;
            send_request(random_request(), 1'b0, no_rsp);
            idle_gap(steady ? 0 : pick_gap());
         end
      end
      wait_idle();

      $display("Covered %0d requests under %0d length settings; %0d replies checked.",
               requests_sent, length_writes, replies_seen);
      $display("List rescrambles predicted: %0d; mismatches: %0d.", rescrambles, mismatches);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
